[rtl/m2l_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package m2l_pkg;

	localparam int unsigned NUM_COEF = 10;

	typedef enum logic [1:0] {
		OP_ACCUM = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Place of the second-derivative kernel H_ab among the ten kernels.
	function automatic logic [3:0] hess_idx(input logic [1:0] a, input logic [1:0] b);
		logic [3:0] r;
		r = 4'd4;
		if (a == b) begin
			r = 4'd4 + {2'd0, a};
		end else if ((a == 2'd0 && b == 2'd1) || (a == 2'd1 && b == 2'd0)) begin
			r = 4'd7;
		end else if ((a == 2'd1 && b == 2'd2) || (a == 2'd2 && b == 2'd1)) begin
			r = 4'd8;
		end else begin
			r = 4'd9;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/m2l_local_translate.sv]
`timescale 1ns / 1ps
`default_nettype none
// Second-order Cartesian multipole-to-local translation for the Coulomb potential.
// An item on the slave side carries an operation code in s_tuser: accumulate adds one
// multipole term's contribution to one, four or all ten local coefficients, clear
// zeroes them and the status flags, read-out emits the ten coefficients as ten items,
// index 0 first, with tlast on the tenth. All multiplication runs through a single
// 32 x 32 bit multiplier under a small sequencer, and the block is not ready while it
// works. A clear, the unused operation code or a term index above nine leaves the
// block in its idle state. An accumulate sums the squared distance components for
// R^2, normalises it by shifts of two bits, takes a bit-serial square root and a
// bit-serial division for 1/R, scales the result and then, for each of the twenty
// kernel products and of the one to ten moment products, selects the operands, adds
// four partial products of the 64 by 64 bit product and finishes it. A read-out
// holds the block for ten output items. A term at zero distance is skipped and
// raises status bit 1; any saturation raises status bit 0.
module m2l_local_translate (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// term_index [3:0], moment [35:4], dx [67:36], dy [99:68], dz [131:100]
	input  wire logic [135:0] s_tdata,
	// op [1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// coef_index [3:0], coef_value [67:4]
	output logic [71:0]       m_tdata,
	// status [1:0]
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_NORM, ST_SQRT, ST_DIV, ST_INV, ST_SEL, ST_MUL, ST_FIN, ST_OUT
	} state_t;

	state_t       state_q;
	logic [3:0]   term_q;
	logic [31:0]  mom_q;
	logic [31:0]  d_q [3];
	logic [63:0]  r2_q;
	logic [1:0]   cnt_q;
	logic [4:0]   e_q;
	logic [4:0]   bit_q;
	logic [31:0]  root_q;
	logic [5:0]   div_q;
	logic [31:0]  rem_q;
	logic [32:0]  quo_q;
	logic [63:0]  kern_q [m2l_pkg::NUM_COEF];
	logic [63:0]  u_q [3];
	logic [63:0]  p2_q, p3_q, tmp_q;
	logic [63:0]  coef_q [m2l_pkg::NUM_COEF];
	logic [1:0]   flags_q;
	logic         sat_q;
	logic [4:0]   step_q;
	logic         acc_q;
	logic [3:0]   j_q;
	logic [63:0]  ua_q, ub_q;
	logic         neg_q, sh32_q;
	logic [127:0] prod_q;
	logic [3:0]   oidx_q;

	// Shared multiplier.
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  mul_p;
	logic [31:0]  dmag;
	logic [31:0]  t_root;

	assign t_root = root_q | (32'd1 << bit_q);
	assign dmag   = d_q[cnt_q][31] ? 32'(-d_q[cnt_q]) : d_q[cnt_q];

	always_comb begin
		mul_a = t_root;
		mul_b = t_root;
		case (state_q)
			ST_SQ: begin
				mul_a = dmag;
				mul_b = dmag;
			end
			ST_MUL: begin
				mul_a = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
				mul_b = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
			end
			default: begin
			end
		endcase
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// Operand selection for the product in hand.
	logic [63:0] op_a, op_b;
	logic        op_sh32;
	logic [3:0]  h_idx;
	logic [1:0]  ha, hb;
	logic [3:0]  acc_c, acc_k, acc_n;
	logic [1:0]  tsub;

	assign h_idx = 4'((step_q - 5'd8) >> 1);
	assign tsub  = 2'(term_q - 4'd1);

	always_comb begin
		case (h_idx)
			4'd0: begin ha = 2'd0; hb = 2'd0; end
			4'd1: begin ha = 2'd1; hb = 2'd1; end
			4'd2: begin ha = 2'd2; hb = 2'd2; end
			4'd3: begin ha = 2'd0; hb = 2'd1; end
			4'd4: begin ha = 2'd1; hb = 2'd2; end
			default: begin ha = 2'd0; hb = 2'd2; end
		endcase
	end

	always_comb begin
		if (term_q == 4'd0) begin
			acc_n = 4'd10;
			acc_c = j_q;
			acc_k = j_q;
		end else if (term_q <= 4'd3) begin
			acc_n = 4'd4;
			acc_c = j_q;
			acc_k = (j_q == 4'd0) ? term_q : m2l_pkg::hess_idx(tsub, 2'(j_q - 4'd1));
		end else begin
			acc_n = 4'd1;
			acc_c = 4'd0;
			acc_k = term_q;
		end
	end

	always_comb begin
		op_a    = kern_q[0];
		op_b    = kern_q[0];
		op_sh32 = 1'b1;
		if (acc_q) begin
			op_a    = {{32{mom_q[31]}}, mom_q};
			op_b    = kern_q[acc_k];
			op_sh32 = 1'b0;
		end else if (step_q == 5'd1) begin
			op_a = p2_q;
		end else if (step_q <= 5'd4 && step_q >= 5'd2) begin
			op_a    = {{32{d_q[2'(step_q - 5'd2)][31]}}, d_q[2'(step_q - 5'd2)]};
			op_sh32 = 1'b0;
		end else if (step_q <= 5'd7 && step_q >= 5'd5) begin
			op_a = u_q[2'(step_q - 5'd5)];
			op_b = p2_q;
		end else if (step_q >= 5'd8) begin
			if (!step_q[0]) begin
				op_a = u_q[ha];
				op_b = u_q[hb];
			end else begin
				// Three times u_a u_b, less one on the diagonal, in wrapping arithmetic.
				op_a = (tmp_q << 1) + tmp_q - ((h_idx < 4'd3) ? 64'h1_0000_0000 : 64'd0);
				op_b = p3_q;
			end
		end
	end

	// Rounding and saturation of the finished product.
	logic        ovf, fsat;
	logic [63:0] qv, lim, qs, res;
	logic [64:0] sum;
	logic [63:0] sum_sat;
	logic        add_ovf;
	logic [63:0] inv_val;
	logic [32:0] rem_n;

	always_comb begin
		ovf  = sh32_q ? (|prod_q[127:96]) : (|prod_q[127:80]);
		qv   = sh32_q ? prod_q[95:32] : prod_q[79:16];
		lim  = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		fsat = ovf || (qv > lim);
		qs   = fsat ? lim : qv;
		res  = neg_q ? 64'(-qs) : qs;
		sum  = {coef_q[acc_c][63], coef_q[acc_c]} + {res[63], res};
		add_ovf = sum[64] != sum[63];
		sum_sat = add_ovf ? (sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
		                  : sum[63:0];
		inv_val = (e_q >= 5'd15) ? ({31'd0, quo_q} << (e_q - 5'd15))
		                         : ({31'd0, quo_q} >> (5'd15 - e_q));
		rem_n   = {rem_q, div_q == 6'd63};
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = state_q == ST_OUT;
	assign m_tdata  = {4'd0, coef_q[oidx_q], oidx_q};
	assign m_tuser  = flags_q;
	assign m_tlast  = oidx_q == 4'(m2l_pkg::NUM_COEF - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flags_q <= 2'd0;
			for (int i = 0; i < m2l_pkg::NUM_COEF; i++) begin
				coef_q[i] <= 64'd0;
			end
			oidx_q  <= 4'd0;
			acc_q   <= 1'b0;
			step_q  <= 5'd0;
			j_q     <= 4'd0;
			cnt_q   <= 2'd0;
			sat_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						term_q <= s_tdata[3:0];
						mom_q  <= s_tdata[35:4];
						d_q[0] <= s_tdata[67:36];
						d_q[1] <= s_tdata[99:68];
						d_q[2] <= s_tdata[131:100];
						case (s_tuser)
							m2l_pkg::OP_ACCUM: begin
								if (s_tdata[3:0] <= 4'd9) begin
									state_q <= ST_SQ;
									cnt_q   <= 2'd0;
									r2_q    <= 64'd0;
									e_q     <= 5'd0;
								end
							end
							m2l_pkg::OP_CLEAR: begin
								flags_q <= 2'd0;
								for (int i = 0; i < m2l_pkg::NUM_COEF; i++) begin
									coef_q[i] <= 64'd0;
								end
							end
							m2l_pkg::OP_READ: begin
								oidx_q  <= 4'd0;
								state_q <= ST_OUT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SQ: begin
					r2_q  <= r2_q + mul_p;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (r2_q == 64'd0) begin
						flags_q[1] <= 1'b1;
						state_q    <= ST_IDLE;
					end else if (r2_q[63:62] == 2'd0) begin
						r2_q <= r2_q << 2;
						e_q  <= e_q + 5'd1;
					end else begin
						root_q  <= 32'd0;
						bit_q   <= 5'd31;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (mul_p <= r2_q) begin
						root_q <= t_root;
					end
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						div_q   <= 6'd63;
						rem_q   <= 32'd0;
						quo_q   <= 33'd0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// The remainder stays below the root, so 32 bits hold it.
					if (rem_n >= {1'b0, root_q}) begin
						rem_q <= 32'(rem_n - {1'b0, root_q});
						quo_q <= {quo_q[31:0], 1'b1};
					end else begin
						rem_q <= rem_n[31:0];
						quo_q <= {quo_q[31:0], 1'b0};
					end
					div_q <= div_q - 6'd1;
					if (div_q == 6'd0) begin
						state_q <= ST_INV;
					end
				end
				ST_INV: begin
					kern_q[0] <= inv_val;
					step_q    <= 5'd0;
					acc_q     <= 1'b0;
					j_q       <= 4'd0;
					sat_q     <= 1'b0;
					state_q   <= ST_SEL;
				end
				ST_SEL: begin
					ua_q    <= op_a[63] ? 64'(-op_a) : op_a;
					ub_q    <= op_b[63] ? 64'(-op_b) : op_b;
					neg_q   <= op_a[63] != op_b[63];
					sh32_q  <= op_sh32;
					prod_q  <= 128'd0;
					cnt_q   <= 2'd0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= prod_q + ({64'd0, mul_p}
						<< {{1'b0, cnt_q[1]} + {1'b0, cnt_q[0]}, 5'd0});
					cnt_q   <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_SEL;
					if (acc_q) begin
						coef_q[acc_c] <= sum_sat;
						j_q <= j_q + 4'd1;
						if (j_q == acc_n - 4'd1) begin
							state_q <= ST_IDLE;
							if (sat_q || fsat || add_ovf) begin
								flags_q[0] <= 1'b1;
							end
						end else begin
							sat_q <= sat_q | fsat | add_ovf;
						end
					end else begin
						sat_q <= sat_q | fsat;
						if (step_q == 5'd0) begin
							p2_q <= res;
						end else if (step_q == 5'd1) begin
							p3_q <= res;
						end else if (step_q <= 5'd4) begin
							u_q[2'(step_q - 5'd2)] <= res;
						end else if (step_q <= 5'd7) begin
							kern_q[4'(step_q - 5'd4)] <= 64'(-res);
						end else if (!step_q[0]) begin
							tmp_q <= res;
						end else begin
							kern_q[4'd4 + h_idx] <= res;
						end
						if (step_q == 5'd19) begin
							acc_q <= 1'b1;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						if (oidx_q == 4'(m2l_pkg::NUM_COEF - 1)) begin
							oidx_q  <= 4'd0;
							state_q <= ST_IDLE;
						end else begin
							oidx_q <= oidx_q + 4'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
